// ===== rtl/arp_acp_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_acp_pkg
// Shared types and constants for the ARP address conflict probe: item and
// result payloads, configuration set, register indexes and protocol codes.
// ----------------------------------------------------------------------------
package arp_acp_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 48;
   localparam int unsigned CFG_IV_W    = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_ARP_ENABLED = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_HW_ADDR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HW_TYPE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROBE_COUNT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLAIM_COUNT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROBE_WAIT  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLAIM_WAIT  = 3'd6;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_RX    = 2'd2;

   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_PROBE    = 3'd1;
   localparam logic [2:0] EV_CLAIM    = 3'd2;
   localparam logic [2:0] EV_FREE     = 3'd3;
   localparam logic [2:0] EV_CONFLICT = 3'd4;

   localparam logic [15:0] OP_REQUEST     = 16'd1;
   localparam logic [15:0] OP_REPLY       = 16'd2;
   localparam logic [15:0] PROTO_IPV4     = 16'h0800;
   localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
   localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
   localparam logic [15:0] MIN_RX_LEN     = 16'd28;

   localparam logic        RST_ARP_ENABLED    = 1'b1;
   localparam logic [47:0] RST_OWN_HW_ADDR    = 48'd0;
   localparam logic [15:0] RST_HW_TYPE        = 16'd1;
   localparam logic [2:0]  RST_PROBE_COUNT    = 3'd3;
   localparam logic [1:0]  RST_CLAIM_COUNT    = 2'd2;
   localparam logic [CFG_IV_W-1:0] RST_INTERVAL = 20'd200000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] target_ip;
      logic [15:0] rx_opcode;
      logic [15:0] rx_proto_type;
      logic [7:0]  rx_proto_len;
      logic [7:0]  rx_hw_len;
      logic [15:0] rx_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] tx_hw_type;
      logic [15:0] tx_opcode;
      logic [47:0] tx_sender_hw;
      logic [31:0] tx_sender_ip;
      logic [47:0] tx_target_hw;
      logic [31:0] tx_target_ip;
      logic        busy_res;
   } rsp_type;

   typedef struct packed {
      logic                arp_enabled;
      logic [47:0]         own_hw_addr;
      logic [15:0]         hw_type;
      logic [2:0]          probe_count;
      logic [1:0]          claim_count;
      logic [CFG_IV_W-1:0] probe_wait;
      logic [CFG_IV_W-1:0] claim_wait;
   } cfg_type;

endpackage

// ===== rtl/arp_acp_csr.sv =====
// ----------------------------------------------------------------------------
// arp_acp_csr
// Configuration register file: one write per cycle, fields masked to their
// widths, reset to their power-on defaults.
// ----------------------------------------------------------------------------
module arp_acp_csr import arp_acp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ARP_ENABLED: cfg_in.arp_enabled = csr_wdata[0];
            CSR_OWN_HW_ADDR: cfg_in.own_hw_addr = csr_wdata[47:0];
            CSR_HW_TYPE:     cfg_in.hw_type     = csr_wdata[15:0];
            CSR_PROBE_COUNT: cfg_in.probe_count = csr_wdata[2:0];
            CSR_CLAIM_COUNT: cfg_in.claim_count = csr_wdata[1:0];
            CSR_PROBE_WAIT:  cfg_in.probe_wait  = csr_wdata[CFG_IV_W-1:0];
            CSR_CLAIM_WAIT:  cfg_in.claim_wait  = csr_wdata[CFG_IV_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arp_enabled <= RST_ARP_ENABLED;
         cfg_ff.own_hw_addr <= RST_OWN_HW_ADDR;
         cfg_ff.hw_type     <= RST_HW_TYPE;
         cfg_ff.probe_count <= RST_PROBE_COUNT;
         cfg_ff.claim_count <= RST_CLAIM_COUNT;
         cfg_ff.probe_wait  <= RST_INTERVAL;
         cfg_ff.claim_wait  <= RST_INTERVAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/arp_acp_core.sv =====
// ----------------------------------------------------------------------------
// arp_acp_core
// Probe sequencer: holds the check state, decodes one item per cycle while
// step_en is high, and forms the result (probe, claim, free, conflict or nothing).
// ----------------------------------------------------------------------------
module arp_acp_core import arp_acp_pkg::*; #(
   parameter int unsigned TIMER_BITS = 20
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic                  active_ff,  active_in;
   logic [2:0]            probes_ff,  probes_in;
   logic [1:0]            claims_ff,  claims_in;
   logic [TIMER_BITS-1:0] wait_ff,    wait_in;
   logic [TIMER_BITS-1:0] cur_iv_ff,  cur_iv_in;
   logic [31:0]           ip_ff,      ip_in;

   logic                  do_adv;
   logic                  hit;
   logic [TIMER_BITS-1:0] probe_iv;
   logic [TIMER_BITS-1:0] claim_iv;

   assign probe_iv = TIMER_BITS'(cfg.probe_wait);
   assign claim_iv = TIMER_BITS'(cfg.claim_wait);

   assign hit = (item.rx_opcode == OP_REPLY) && (item.rx_proto_type == PROTO_IPV4) &&
                (item.rx_proto_len == PROTO_ADDR_LEN) && (item.rx_hw_len == HW_ADDR_LEN) &&
                (item.rx_length >= MIN_RX_LEN);

   always_comb begin
      active_in = active_ff;
      probes_in = probes_ff;
      claims_in = claims_ff;
      wait_in   = wait_ff;
      cur_iv_in = cur_iv_ff;
      ip_in     = ip_ff;
      do_adv    = 1'b0;
      result    = '0;

      case (item.kind)
         KIND_START: begin
            ip_in     = item.target_ip;
            probes_in = '0;
            claims_in = '0;
            wait_in   = '0;
            cur_iv_in = '0;
            if (!cfg.arp_enabled) begin
               active_in        = 1'b0;
               result.event_res = EV_FREE;
            end else begin
               active_in = 1'b1;
               do_adv    = 1'b1;
            end
         end
         KIND_TICK: begin
            if (active_ff) begin
               if (wait_ff <= TIMER_BITS'(1)) begin
                  wait_in = '0;
                  do_adv  = 1'b1;
               end else begin
                  wait_in = wait_ff - TIMER_BITS'(1);
               end
            end
         end
         KIND_RX: begin
            if (active_ff) begin
               if (hit) begin
                  active_in        = 1'b0;
                  result.event_res = EV_CONFLICT;
               end else begin
                  wait_in = cur_iv_ff;
               end
            end
         end
         default: begin
            active_in = active_ff;
         end
      endcase

      if (do_adv) begin
         if (probes_in < cfg.probe_count) begin
            probes_in           = probes_in + 3'd1;
            cur_iv_in           = probe_iv;
            wait_in             = probe_iv;
            result.event_res    = EV_PROBE;
            result.tx_hw_type   = cfg.hw_type;
            result.tx_opcode    = OP_REQUEST;
            result.tx_sender_hw = cfg.own_hw_addr;
            result.tx_target_ip = ip_in;
         end else if (claims_in < cfg.claim_count) begin
            claims_in           = claims_in + 2'd1;
            cur_iv_in           = claim_iv;
            wait_in             = claim_iv;
            result.event_res    = EV_CLAIM;
            result.tx_hw_type   = cfg.hw_type;
            result.tx_opcode    = OP_REQUEST;
            result.tx_sender_hw = cfg.own_hw_addr;
            result.tx_sender_ip = ip_in;
            result.tx_target_hw = cfg.own_hw_addr;
            result.tx_target_ip = ip_in;
         end else begin
            active_in        = 1'b0;
            result.event_res = EV_FREE;
         end
      end

      result.busy_res = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         probes_ff <= '0;
         claims_ff <= '0;
         wait_ff   <= '0;
         cur_iv_ff <= '0;
         ip_ff     <= '0;
      end else if (step_en) begin
         active_ff <= active_in;
         probes_ff <= probes_in;
         claims_ff <= claims_in;
         wait_ff   <= wait_in;
         cur_iv_ff <= cur_iv_in;
         ip_ff     <= ip_in;
      end
   end

endmodule

// ===== rtl/arp_address_conflict_probe.sv =====
// ----------------------------------------------------------------------------
// arp_address_conflict_probe
// Checks an IPv4 address with ARP probes and claims and reports it free, or
// in conflict when a valid ARP reply arrives.
//
//   Channel  Ports                          Direction  Content
//   req      req_valid req_stall req_data   in         tick, start, rx header
//   rsp      rsp_valid rsp_stall rsp_data   out        one result per item
//   csr      csr_write_en csr_index csr_wdata in       configuration write
//
// One item per cycle sustained while rsp_stall is low; an accepted item is held
// in the input register and its result is then held in the result register.
// Reset is synchronous; the check state goes idle, config takes defaults.
// A stalled result holds in the output register while one more item waits
// in the input register; req_stall rises only when both are full.
// ----------------------------------------------------------------------------
module arp_address_conflict_probe import arp_acp_pkg::*; #(
   parameter int unsigned TIMER_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type item_ff;
   rsp_type rsp_ff;
   rsp_type result;
   logic    item_valid_ff, item_valid_in;
   logic    rsp_valid_ff,  rsp_valid_in;
   logic    step_en;
   logic    req_xfer;

   arp_acp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   arp_acp_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign step_en   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !step_en;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_xfer) begin
         item_valid_in = 1'b1;
      end else if (step_en) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_data;
      end
      if (step_en) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && rsp_valid_ff && rsp_stall) |=> item_valid_ff)
      else $error("queued item lost while result stalled");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.event_res <= EV_CONFLICT))
      else $error("result event code out of range");

   a_send_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.event_res == EV_PROBE || rsp_ff.event_res == EV_CLAIM))
      |-> (rsp_ff.busy_res && rsp_ff.tx_opcode == OP_REQUEST))
      else $error("frame sent without check in progress");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.event_res == EV_FREE || rsp_ff.event_res == EV_CONFLICT))
      |-> !rsp_ff.busy_res)
      else $error("check ended but still busy");

endmodule

// ===== bench/arp_address_conflict_probe_checker.sv =====
// ----------------------------------------------------------------------------
// arp_address_conflict_probe_checker
// Watches the request, result and register ports of the ARP conflict probe.
// Keeps its own copy of the registers and of the probe/claim sequencer,
// predicts one result per accepted request and compares every result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module arp_address_conflict_probe_checker import arp_acp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            fail_count,
   output int unsigned            pending,
   output logic                   busy_predicted
);

   timeunit 1ns;
   timeprecision 1ps;

   cfg_type             regs;
   logic                checking;
   logic [2:0]          probes_done;
   logic [1:0]          claims_done;
   logic [CFG_IV_W-1:0] ticks_left;
   logic [CFG_IV_W-1:0] reload_ticks;
   logic [31:0]         probe_ip;
   rsp_type             arp_results_due[$];
   rsp_type             got;
   rsp_type             want;

   initial begin
      fail_count = 0;
      pending    = 0;
      checking   = 1'b0;
   end

   assign busy_predicted = checking;

   task automatic send_next_frame(inout rsp_type r);
      if (probes_done < regs.probe_count) begin
         probes_done  = probes_done + 1'b1;
         reload_ticks = regs.probe_wait;
         ticks_left   = reload_ticks;
         r.event_res  = EV_PROBE;
      end else if (claims_done < regs.claim_count) begin
         claims_done    = claims_done + 1'b1;
         reload_ticks   = regs.claim_wait;
         ticks_left     = reload_ticks;
         r.event_res    = EV_CLAIM;
         r.tx_sender_ip = probe_ip;
         r.tx_target_hw = regs.own_hw_addr;
      end else begin
         checking    = 1'b0;
         r.event_res = EV_FREE;
      end
      if (r.event_res == EV_PROBE || r.event_res == EV_CLAIM) begin
         r.tx_hw_type   = regs.hw_type;
         r.tx_opcode    = OP_REQUEST;
         r.tx_sender_hw = regs.own_hw_addr;
         r.tx_target_ip = probe_ip;
      end
   endtask

   task automatic next_arp_result(input req_type item, output rsp_type r);
      r = '0;
      case (item.kind)
         KIND_START: begin
            probe_ip     = item.target_ip;
            probes_done  = '0;
            claims_done  = '0;
            ticks_left   = '0;
            reload_ticks = '0;
            if (!regs.arp_enabled) begin
               checking    = 1'b0;
               r.event_res = EV_FREE;
            end else begin
               checking = 1'b1;
               send_next_frame(r);
            end
         end
         KIND_TICK: begin
            if (checking) begin
               if (ticks_left <= 1) begin
                  ticks_left = '0;
                  send_next_frame(r);
               end else begin
                  ticks_left = ticks_left - 1'b1;
               end
            end
         end
         KIND_RX: begin
            if (checking) begin
               if (item.rx_opcode == OP_REPLY && item.rx_proto_type == PROTO_IPV4 &&
                   item.rx_proto_len == PROTO_ADDR_LEN && item.rx_hw_len == HW_ADDR_LEN &&
                   item.rx_length >= MIN_RX_LEN) begin
                  checking    = 1'b0;
                  r.event_res = EV_CONFLICT;
               end else begin
                  ticks_left = reload_ticks;
               end
            end
         end
         default: ;
      endcase
      r.busy_res = checking;
   endtask

   task automatic compare_field(input string name, input logic [47:0] exp_val,
                                input logic [47:0] act_val);
      if (exp_val !== act_val) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs = '{arp_enabled: RST_ARP_ENABLED, own_hw_addr: RST_OWN_HW_ADDR,
                  hw_type: RST_HW_TYPE, probe_count: RST_PROBE_COUNT,
                  claim_count: RST_CLAIM_COUNT, probe_wait: RST_INTERVAL,
                  claim_wait: RST_INTERVAL};
         checking     = 1'b0;
         probes_done  = '0;
         claims_done  = '0;
         ticks_left   = '0;
         reload_ticks = '0;
         probe_ip     = '0;
         arp_results_due.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_ARP_ENABLED: regs.arp_enabled = csr_wdata[0];
               CSR_OWN_HW_ADDR: regs.own_hw_addr = csr_wdata[47:0];
               CSR_HW_TYPE:     regs.hw_type     = csr_wdata[15:0];
               CSR_PROBE_COUNT: regs.probe_count = csr_wdata[2:0];
               CSR_CLAIM_COUNT: regs.claim_count = csr_wdata[1:0];
               CSR_PROBE_WAIT:  regs.probe_wait  = csr_wdata[CFG_IV_W-1:0];
               CSR_CLAIM_WAIT:  regs.claim_wait  = csr_wdata[CFG_IV_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (arp_results_due.size() == 0) begin
               fail_count++;
               $display("%0t: result transfer with no expectation, expected none, actual %h",
                        $time, got);
            end else begin
               want = arp_results_due.pop_front();
               compare_field("event_res", want.event_res, got.event_res);
               compare_field("tx_hw_type", want.tx_hw_type, got.tx_hw_type);
               compare_field("tx_opcode", want.tx_opcode, got.tx_opcode);
               compare_field("tx_sender_hw", want.tx_sender_hw, got.tx_sender_hw);
               compare_field("tx_sender_ip", want.tx_sender_ip, got.tx_sender_ip);
               compare_field("tx_target_hw", want.tx_target_hw, got.tx_target_hw);
               compare_field("tx_target_ip", want.tx_target_ip, got.tx_target_ip);
               compare_field("busy_res", want.busy_res, got.busy_res);
            end
         end
         if (req_valid && !req_stall) begin
            next_arp_result(req_data, want);
            arp_results_due.push_back(want);
         end
      end
      pending = arp_results_due.size();
   end

endmodule

// ===== bench/arp_address_conflict_probe_test.sv =====
// ----------------------------------------------------------------------------
// arp_address_conflict_probe_test
// Drives ticks, start requests and received ARP headers into the conflict
// probe under several register settings, with bursty input and a stalling
// result side. A directed opening covers the field extremes and corner
// cases; random phases then run probe/claim sequences to completion or
// conflict. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module arp_address_conflict_probe_test;

   timeunit 1ns;
   timeprecision 1ps;

   import arp_acp_pkg::*;

   localparam logic [1:0]  KIND_UNUSED   = 2'd3;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned ITEM_TARGET   = 1150;
   localparam int unsigned PHASE_ITEMS   = 150;
   localparam int unsigned HOLD_CYCLES   = 300;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_type                req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   int unsigned fail_count;
   int unsigned pending;
   logic        busy_predicted;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;

   arp_address_conflict_probe dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   arp_address_conflict_probe_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending),
      .busy_predicted (busy_predicted)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("arp_address_conflict_probe_test NOT OK");
         $finish;
      end
   end

   function automatic req_type noise_item();
      logic [127:0] raw;
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type kind_item(logic [1:0] kind);
      req_type r;
      r      = noise_item();
      r.kind = kind;
      return r;
   endfunction

   function automatic req_type start_item(logic [31:0] ip);
      req_type r;
      r           = kind_item(KIND_START);
      r.target_ip = ip;
      return r;
   endfunction

   function automatic req_type arp_reply(logic [15:0] len);
      req_type r;
      r               = kind_item(KIND_RX);
      r.rx_opcode     = OP_REPLY;
      r.rx_proto_type = PROTO_IPV4;
      r.rx_proto_len  = PROTO_ADDR_LEN;
      r.rx_hw_len     = HW_ADDR_LEN;
      r.rx_length     = len;
      return r;
   endfunction

   function automatic req_type spoil_reply(req_type r, int unsigned which);
      case (which)
         0: r.rx_opcode     = OP_REPLY ^ 16'($urandom_range(1, 65535));
         1: r.rx_proto_type = PROTO_IPV4 ^ 16'($urandom_range(1, 65535));
         2: r.rx_proto_len  = PROTO_ADDR_LEN ^ 8'($urandom_range(1, 255));
         3: r.rx_hw_len     = HW_ADDR_LEN ^ 8'($urandom_range(1, 255));
         default: r.rx_length = 16'($urandom_range(0, MIN_RX_LEN - 1));
      endcase
      return r;
   endfunction

   function automatic req_type random_item();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (!busy_predicted && $urandom_range(0, 9) < 4) return start_item($urandom());
      if (pick < 78) return kind_item(KIND_TICK);
      if (pick < 82) return start_item($urandom());
      if (pick < 85) return arp_reply(16'($urandom_range(MIN_RX_LEN, 65535)));
      if (pick < 93) begin
         return spoil_reply(arp_reply(16'($urandom_range(MIN_RX_LEN, 65535))),
                            $urandom_range(0, 4));
      end
      if (pick < 97) return kind_item(KIND_RX);
      return kind_item(KIND_UNUSED);
   endfunction

   function automatic cfg_type random_config(int unsigned phase);
      cfg_type c;
      c.arp_enabled = ($urandom_range(0, 7) != 0);
      c.own_hw_addr = 48'({$urandom(), $urandom()});
      c.hw_type     = 16'($urandom());
      c.probe_count = 3'($urandom_range(0, 7));
      c.claim_count = 2'($urandom_range(0, 3));
      c.probe_wait  = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 40))
                                                   : 20'($urandom_range(0, 5));
      c.claim_wait  = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 40))
                                                   : 20'($urandom_range(0, 5));
      case (phase)
         0: begin
            c.arp_enabled = 1'b1;
            c.probe_count = 3'd7;
            c.claim_count = 2'd3;
         end
         1: begin
            c.arp_enabled = 1'b1;
            c.probe_count = 3'd0;
            c.claim_count = 2'd3;
         end
         2: begin
            c.arp_enabled = 1'b1;
            c.probe_count = 3'd7;
            c.claim_count = 2'd0;
         end
         3: begin
            c.arp_enabled = 1'b1;
            c.probe_wait  = 20'd1;
            c.claim_wait  = 20'd1;
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic send_item(input req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
         if ($urandom_range(0, 19) == 0) gap = 20;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input cfg_type c);
      write_csr(CSR_ARP_ENABLED, CSR_DATA_W'(c.arp_enabled));
      write_csr(CSR_OWN_HW_ADDR, CSR_DATA_W'(c.own_hw_addr));
      write_csr(CSR_HW_TYPE, CSR_DATA_W'(c.hw_type));
      write_csr(CSR_PROBE_COUNT, CSR_DATA_W'(c.probe_count));
      write_csr(CSR_CLAIM_COUNT, CSR_DATA_W'(c.claim_count));
      write_csr(CSR_PROBE_WAIT, CSR_DATA_W'(c.probe_wait));
      write_csr(CSR_CLAIM_WAIT, CSR_DATA_W'(c.claim_wait));
   endtask

   // receiver: stall patterns, with a long hold-off while the sender is busy
   initial begin
      int unsigned mode;
      int unsigned span;
      int unsigned beat;
      int unsigned hold_in;
      hold_in = 1500;
      beat    = 0;
      while (reset) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            beat++;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= ((beat % 5) < 2);
            endcase
         end
         if (hold_in > span) begin
            hold_in = hold_in - span;
         end else begin
            @(posedge clock);
            while (!req_valid) @(posedge clock);
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_in = $urandom_range(2000, 4000);
         end
      end
   end

   initial begin
      cfg_type     c;
      req_type     item;
      int unsigned effective;
      int unsigned phase;
      int unsigned phase_items;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      c = '{arp_enabled: 1'b1, own_hw_addr: 48'hFFFF_FFFF_FFFF, hw_type: 16'hFFFF,
            probe_count: 3'd1, claim_count: 2'd1, probe_wait: 20'd0,
            claim_wait: 20'd2};
      set_config(c);
      send_item(kind_item(KIND_TICK));
      send_item(arp_reply(MIN_RX_LEN));
      send_item(kind_item(KIND_UNUSED));
      send_item(start_item(32'hFFFF_FFFF));
      send_item(kind_item(KIND_TICK));
      send_item(kind_item(KIND_TICK));
      item = arp_reply(MIN_RX_LEN);
      item.rx_opcode = OP_REQUEST;
      send_item(item);
      send_item(kind_item(KIND_TICK));
      send_item(kind_item(KIND_TICK));
      send_item(start_item(32'h0000_0000));
      send_item(start_item(32'h0A00_0001));
      send_item(kind_item(KIND_UNUSED));
      send_item(arp_reply(MIN_RX_LEN - 1));
      item = arp_reply(16'hFFFF);
      item.rx_proto_type = 16'h0806;
      send_item(item);
      item = arp_reply(16'hFFFF);
      item.rx_hw_len = 8'd5;
      send_item(item);
      item = arp_reply(16'hFFFF);
      item.rx_proto_len = 8'd3;
      send_item(item);
      send_item(arp_reply(MIN_RX_LEN));
      send_item(start_item(32'h8000_0000));
      send_item(arp_reply(16'hFFFF));
      drain();

      c = '{arp_enabled: 1'b0, own_hw_addr: 48'h0, hw_type: 16'h0, probe_count: 3'd7,
            claim_count: 2'd3, probe_wait: 20'hFFFFF, claim_wait: 20'hFFFFF};
      set_config(c);
      send_item(start_item(32'h7FFF_FFFF));
      send_item(kind_item(KIND_TICK));
      drain();

      c.arp_enabled = 1'b1;
      c.probe_count = 3'd0;
      c.claim_count = 2'd0;
      set_config(c);
      send_item(start_item(32'hC0A8_0001));
      drain();

      c.probe_count = 3'd2;
      c.claim_count = 2'd1;
      c.claim_wait  = 20'd1;
      set_config(c);
      send_item(start_item(32'hC0A8_0002));
      repeat (3) send_item(kind_item(KIND_TICK));
      send_item(spoil_reply(arp_reply(MIN_RX_LEN), 4));
      send_item(kind_item(KIND_TICK));
      drain();

      effective = 30;
      phase     = 0;
      while (effective < ITEM_TARGET) begin
         set_config(random_config(phase));
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && effective < ITEM_TARGET) begin
            item = random_item();
            if (item.kind == KIND_START || (item.kind != KIND_UNUSED && busy_predicted)) begin
               effective++;
               phase_items++;
            end
            send_item(item);
         end
         drain();
         phase++;
      end

      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("arp_address_conflict_probe_test OK");
      end else begin
         $display("arp_address_conflict_probe_test NOT OK");
      end
      $finish;
   end

endmodule
